// ----- sv/cmfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cmfd_pkg
// Shared types and constants of the motor feedback decoder: frame
// identifiers, result kinds, the decoded item and the per-slot state entry.
// ----------------------------------------------------------------------------
package cmfd_pkg;

	localparam logic [10:0] ID_MOTOR_1   = 11'h201;
	localparam logic [10:0] ID_MOTOR_2   = 11'h202;
	localparam logic [10:0] ID_MOTOR_3   = 11'h203;
	localparam logic [10:0] ID_MOTOR_4   = 11'h204;
	localparam logic [10:0] ID_MOTOR_5   = 11'h205;
	localparam logic [10:0] ID_MOTOR_6   = 11'h207;
	localparam logic [10:0] ID_GIMBAL    = 11'h400;
	localparam logic [10:0] ID_GIMBAL_SW = 11'h600;

	localparam logic [2:0] SLOT_BUS2_MOTOR = 3'd4;
	localparam logic [2:0] SLOT_LAST_MOTOR = 3'd5;

	localparam logic [1:0] KIND_NONE      = 2'd0;
	localparam logic [1:0] KIND_MOTOR     = 2'd1;
	localparam logic [1:0] KIND_GIMBAL    = 2'd2;
	localparam logic [1:0] KIND_GIMBAL_SW = 2'd3;

	localparam logic [3:0] SWITCH_LOW_MASK = 4'hF;

	typedef struct packed {
		logic        motor;
		logic [1:0]  kind;
		logic [2:0]  slot;
		logic [15:0] word_a;
		logic [15:0] word_b;
		logic [15:0] word_c;
		logic [15:0] word_d;
		logic [7:0]  temperature;
		logic [7:0]  switch_high;
		logic [3:0]  switch_low;
	} frame_t;

	typedef struct packed {
		logic [15:0] enc;
		logic [31:0] ofs;
	} entry_t;

endpackage

// ----- sv/cmfd_decode.sv -----
// ----------------------------------------------------------------------------
// cmfd_decode
// Routes one received frame by bus and identifier and unpacks the payload
// words into the fields of the result item; the angle is left to the core.
// ----------------------------------------------------------------------------
module cmfd_decode (
	input  logic               bus,
	input  logic [10:0]        frame_id,
	input  logic [63:0]        payload,
	output cmfd_pkg::frame_t   frame
);

	logic [15:0] w0;
	logic [15:0] w1;
	logic [15:0] w2;
	logic [15:0] w3;

	assign w0 = payload[63:48];
	assign w1 = payload[47:32];
	assign w2 = payload[31:16];
	assign w3 = payload[15:0];

	always_comb begin
		frame = '0;
		unique case (frame_id)
			cmfd_pkg::ID_MOTOR_1, cmfd_pkg::ID_MOTOR_2,
			cmfd_pkg::ID_MOTOR_3, cmfd_pkg::ID_MOTOR_4: begin
				if (!bus) begin
					frame.motor = 1'b1;
					frame.slot  = 3'(frame_id - cmfd_pkg::ID_MOTOR_1);
				end
			end
			cmfd_pkg::ID_MOTOR_6: begin
				if (!bus) begin
					frame.motor = 1'b1;
					frame.slot  = cmfd_pkg::SLOT_LAST_MOTOR;
				end
			end
			cmfd_pkg::ID_MOTOR_5: begin
				if (bus) begin
					frame.motor = 1'b1;
					frame.slot  = cmfd_pkg::SLOT_BUS2_MOTOR;
				end
			end
			cmfd_pkg::ID_GIMBAL: begin
				if (bus) begin
					frame.kind   = cmfd_pkg::KIND_GIMBAL;
					frame.word_a = 16'(16'd0 - w0);
					frame.word_b = w1;
					frame.word_c = w2;
					frame.word_d = w3;
				end
			end
			cmfd_pkg::ID_GIMBAL_SW: begin
				if (bus) begin
					frame.kind        = cmfd_pkg::KIND_GIMBAL_SW;
					frame.word_a      = 16'(16'd0 - w0);
					frame.word_b      = w1;
					frame.word_c      = w2;
					frame.word_d      = w3;
					frame.switch_high = w2[15:8];
					frame.switch_low  = w2[3:0] & cmfd_pkg::SWITCH_LOW_MASK;
				end
			end
			default: begin
				frame = '0;
			end
		endcase
		if (frame.motor) begin
			frame.kind        = cmfd_pkg::KIND_MOTOR;
			frame.word_a      = w1;
			frame.word_b      = w2;
			frame.word_c      = w0;
			frame.temperature = payload[15:8];
		end
	end

endmodule

// ----- sv/can_motor_feedback_decoder_core.sv -----
// ----------------------------------------------------------------------------
// can_motor_feedback_decoder_core
// Decodes received motor feedback and gimbal frames; unwraps each motor's
// encoder into a multi-turn angle kept in a small per-slot state memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one frame per item: bus,
//   frame_id and payload. Output channel (out_valid/out_stall) gives exactly
//   one result item per frame, in order; kind 0 marks an ignored frame.
//   An accepted frame passes the working stage and then the output
//   register, which raises out_valid. One item is taken every cycle while
//   the output is not stalled: the state memory is read when a frame is
//   accepted and written back as the item leaves the working stage, with
//   the write forwarded to a read of the same slot.
//   The memory holds per slot the last encoder count and the turn offset
//   (turns times counts per turn). Reset clears the entry valid bits, the
//   warm-up counter and all valid flags; an entry not yet written reads zero.
//   No clearing pass is needed.
//   While out_stall holds, the finished result stays in the output register
//   and one more item is taken into the working stage; further items see
//   in_stall until the output drains.
// ----------------------------------------------------------------------------
module can_motor_feedback_decoder_core #(
	parameter int MOTOR_SLOTS     = 6,
	parameter int WARMUP_FRAMES   = 10,
	parameter int COUNTS_PER_TURN = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                bus,
	input  logic [10:0]         frame_id,
	input  logic [63:0]         payload,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          kind,
	output logic [2:0]          slot,
	output logic signed [31:0]  angle,
	output logic [15:0]         word_a,
	output logic [15:0]         word_b,
	output logic [15:0]         word_c,
	output logic [15:0]         word_d,
	output logic [7:0]          temperature,
	output logic [7:0]          switch_high,
	output logic [3:0]          switch_low
);

	localparam int AW     = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
	localparam int DEPTH  = 2 ** AW;
	localparam int WARM_W = $clog2(WARMUP_FRAMES + 2);
	localparam logic [3:0]          SLOTS_L   = 4'(MOTOR_SLOTS);
	localparam logic [WARM_W-1:0]   WARM_LAST = WARM_W'(WARMUP_FRAMES);
	localparam logic signed [17:0]  HALF      = 18'(COUNTS_PER_TURN / 2);
	localparam logic [31:0]         TURN      = 32'(COUNTS_PER_TURN);

	cmfd_pkg::frame_t dec;
	cmfd_pkg::frame_t in_frame;
	cmfd_pkg::frame_t frame_s1;
	cmfd_pkg::entry_t mem [MOTOR_SLOTS];
	cmfd_pkg::entry_t mem_rd_s1;
	cmfd_pkg::entry_t fwd_data_s1;
	cmfd_pkg::entry_t cur;
	cmfd_pkg::entry_t wr_data;

	logic              s1_vld_q;
	logic              out_vld_q;
	logic              s1_adv;
	logic              in_acc;
	logic              wr_en;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [DEPTH-1:0]  vld_q;
	logic              ent_vld_s1;
	logic              fwd_s1;
	logic [WARM_W-1:0] warm_q;
	logic              warming;
	logic signed [16:0] delta;
	logic [31:0]       ofs_new;
	logic [31:0]       angle_new;

	cmfd_decode u_decode (
		.bus      (bus),
		.frame_id (frame_id),
		.payload  (payload),
		.frame    (dec)
	);

	always_comb begin
		in_frame = dec;
		if (dec.motor && ({1'b0, dec.slot} >= SLOTS_L)) begin
			in_frame = '0;
		end
	end

	assign s1_adv   = s1_vld_q && (!out_vld_q || !out_stall);
	assign in_stall = s1_vld_q && !s1_adv;
	assign in_acc   = in_valid && !in_stall;
	assign rd_addr  = in_frame.slot[AW-1:0];
	assign wr_addr  = frame_s1.slot[AW-1:0];
	assign wr_en    = s1_adv && frame_s1.motor;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (in_acc) begin
			mem_rd_s1   <= mem[rd_addr];
			fwd_data_s1 <= wr_data;
			frame_s1    <= in_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q   <= 1'b0;
			vld_q      <= '0;
			ent_vld_s1 <= 1'b0;
			fwd_s1     <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_vld_q   <= 1'b1;
				ent_vld_s1 <= in_frame.motor && vld_q[rd_addr];
				fwd_s1     <= wr_en && in_frame.motor && (wr_addr == rd_addr);
			end else if (s1_adv) begin
				s1_vld_q <= 1'b0;
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_comb begin
		if (fwd_s1) begin
			cur = fwd_data_s1;
		end else if (ent_vld_s1) begin
			cur = mem_rd_s1;
		end else begin
			cur = '0;
		end
	end

	assign warming = (warm_q <= WARM_LAST);
	assign delta   = $signed({1'b0, frame_s1.word_c}) - $signed({1'b0, cur.enc});

	always_comb begin
		ofs_new = cur.ofs;
		if (warming) begin
			ofs_new = '0;
		end else if ($signed({delta[16], delta}) < -HALF) begin
			ofs_new = cur.ofs + TURN;
		end else if ($signed({delta[16], delta}) > HALF) begin
			ofs_new = cur.ofs - TURN;
		end
		angle_new   = ofs_new + {16'd0, frame_s1.word_c};
		wr_data.enc = frame_s1.word_c;
		wr_data.ofs = ofs_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (wr_en && warming) begin
				warm_q <= warm_q + 1'b1;
			end
			if (s1_adv) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			kind        <= frame_s1.kind;
			slot        <= frame_s1.slot;
			angle       <= frame_s1.motor ? $signed(angle_new) : '0;
			word_a      <= frame_s1.word_a;
			word_b      <= frame_s1.word_b;
			word_c      <= frame_s1.word_c;
			word_d      <= frame_s1.word_d;
			temperature <= frame_s1.temperature;
			switch_high <= frame_s1.switch_high;
			switch_low  <= frame_s1.switch_low;
		end
	end

	assign out_valid = out_vld_q;

	a_non_motor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != cmfd_pkg::KIND_MOTOR) |-> (slot == '0) && (angle == '0))
		else $error("non-motor item carries slot or angle");

	a_warm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		warm_q <= WARM_W'(WARMUP_FRAMES + 1))
		else $error("warm-up counter past its hold value");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_vld_q && out_vld_q)
		else $error("input stalled with room in the pipeline");

	a_written_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> vld_q[$past(wr_addr)])
		else $error("written slot not marked valid");

endmodule

// ----- dv/can_motor_feedback_decoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// can_motor_feedback_decoder_core_tb
// Drives received frames into the decoder and checks every result item in
// order against a frame decoder with its own per-slot encoder and turn state.
// A short directed part covers the warm-up, both wrap directions, the half-
// turn boundaries, gimbal frames and frames on the wrong bus. Random frames
// follow: mostly motor frames on rotating encoders, plus gimbal and noise
// frames. Both sides stall at random, with one long output hold-off, and the
// pipeline drains after the directed part and at the end.
// ----------------------------------------------------------------------------
module can_motor_feedback_decoder_core_tb;

	localparam int COUNTS_PER_TURN = 8192;
	localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
	localparam int WARMUP_FRAMES   = 10;
	localparam int IDLE_PCT        = 24;
	localparam int CYCLE_LIMIT     = 200000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  slot;
		logic [31:0] angle;
		logic [15:0] word_a;
		logic [15:0] word_b;
		logic [15:0] word_c;
		logic [15:0] word_d;
		logic [7:0]  temperature;
		logic [7:0]  switch_high;
		logic [3:0]  switch_low;
	} result_t;

	class decode_scoreboard;
		result_t     pending_results[$];
		logic [15:0] enc_last [6];
		logic [31:0] turns [6];
		int unsigned warmup;
		int          errors;

		function new();
			foreach (enc_last[i]) begin
				enc_last[i] = '0;
				turns[i]    = '0;
			end
			warmup = 0;
			errors = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want) begin
				report($sformatf("%s got %h expected %h", name, got, want));
			end
		endtask

		function void note_frame(logic b, logic [10:0] id, logic [63:0] pl);
			result_t     r;
			int          s;
			int          delta;
			logic [15:0] enc;
			r   = '0;
			s   = -1;
			enc = pl[63:48];
			if (!b && id >= cmfd_pkg::ID_MOTOR_1 && id <= cmfd_pkg::ID_MOTOR_4) begin
				s = int'(id - cmfd_pkg::ID_MOTOR_1);
			end else if (!b && id == cmfd_pkg::ID_MOTOR_6) begin
				s = int'(cmfd_pkg::SLOT_LAST_MOTOR);
			end else if (b && id == cmfd_pkg::ID_MOTOR_5) begin
				s = int'(cmfd_pkg::SLOT_BUS2_MOTOR);
			end
			if (s >= 0) begin
				if (warmup <= WARMUP_FRAMES) begin
					turns[s] = '0;
					r.angle  = {16'd0, enc};
					warmup++;
				end else begin
					delta = int'(enc) - int'(enc_last[s]);
					if (delta < -HALF_TURN) begin
						turns[s] = turns[s] + 32'd1;
					end else if (delta > HALF_TURN) begin
						turns[s] = turns[s] - 32'd1;
					end
					r.angle = turns[s] * 32'(COUNTS_PER_TURN) + {16'd0, enc};
				end
				enc_last[s]   = enc;
				r.kind        = cmfd_pkg::KIND_MOTOR;
				r.slot        = 3'(s);
				r.word_a      = pl[47:32];
				r.word_b      = pl[31:16];
				r.word_c      = enc;
				r.temperature = pl[15:8];
			end else if (b && (id == cmfd_pkg::ID_GIMBAL || id == cmfd_pkg::ID_GIMBAL_SW)) begin
				r.kind   = (id == cmfd_pkg::ID_GIMBAL_SW) ? cmfd_pkg::KIND_GIMBAL_SW
					: cmfd_pkg::KIND_GIMBAL;
				r.word_a = 16'd0 - pl[63:48];
				r.word_b = pl[47:32];
				r.word_c = pl[31:16];
				r.word_d = pl[15:0];
				if (id == cmfd_pkg::ID_GIMBAL_SW) begin
					r.switch_high = pl[31:24];
					r.switch_low  = pl[19:16] & cmfd_pkg::SWITCH_LOW_MASK;
				end
			end else begin
				r.kind = cmfd_pkg::KIND_NONE;
			end
			pending_results.push_back(r);
		endfunction

		task check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result item with nothing expected, kind %0d", got.kind));
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 32'(got.kind), 32'(want.kind));
				check_field("slot", 32'(got.slot), 32'(want.slot));
				check_field("angle", got.angle, want.angle);
				check_field("word_a", 32'(got.word_a), 32'(want.word_a));
				check_field("word_b", 32'(got.word_b), 32'(want.word_b));
				check_field("word_c", 32'(got.word_c), 32'(want.word_c));
				check_field("word_d", 32'(got.word_d), 32'(want.word_d));
				check_field("temperature", 32'(got.temperature), 32'(want.temperature));
				check_field("switch_high", 32'(got.switch_high), 32'(want.switch_high));
				check_field("switch_low", 32'(got.switch_low), 32'(want.switch_low));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               bus;
	logic [10:0]        frame_id;
	logic [63:0]        payload;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         kind;
	logic [2:0]         slot;
	logic signed [31:0] angle;
	logic [15:0]        word_a;
	logic [15:0]        word_b;
	logic [15:0]        word_c;
	logic [15:0]        word_d;
	logic [7:0]         temperature;
	logic [7:0]         switch_high;
	logic [3:0]         switch_low;

	decode_scoreboard sb;
	bit               tx_idle_en;
	bit               rx_idle_en;
	int               hold_left;
	int               cycle_count;
	logic [15:0]      stim_enc [6];
	bit               spin_up [6];

	can_motor_feedback_decoder_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.bus        (bus),
		.frame_id   (frame_id),
		.payload    (payload),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.slot       (slot),
		.angle      (angle),
		.word_a     (word_a),
		.word_b     (word_b),
		.word_c     (word_c),
		.word_d     (word_d),
		.temperature(temperature),
		.switch_high(switch_high),
		.switch_low (switch_low)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#4 clk = ~clk;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("can_motor_feedback_decoder_core verification failed");
		$finish;
	end

	// hold off while hold_left counts down, otherwise stall at random
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= rx_idle_en && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_frame(bus, frame_id, payload);
			end
			if (out_valid && !out_stall) begin
				got.kind        = kind;
				got.slot        = slot;
				got.angle       = angle;
				got.word_a      = word_a;
				got.word_b      = word_b;
				got.word_c      = word_c;
				got.word_d      = word_d;
				got.temperature = temperature;
				got.switch_high = switch_high;
				got.switch_low  = switch_low;
				sb.check_result(got);
			end
		end
	end

	task automatic send_frame(input logic b, input logic [10:0] id, input logic [63:0] pl);
		while (tx_idle_en && ($urandom_range(99) < IDLE_PCT)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		bus      <= b;
		frame_id <= id;
		payload  <= pl;
		do begin
			@(posedge clk);
		end while (in_stall);
	endtask

	task automatic send_motor(input int s, input logic [15:0] enc);
		logic [10:0] id;
		case (s)
			0: id = cmfd_pkg::ID_MOTOR_1;
			1: id = cmfd_pkg::ID_MOTOR_2;
			2: id = cmfd_pkg::ID_MOTOR_3;
			3: id = cmfd_pkg::ID_MOTOR_4;
			4: id = cmfd_pkg::ID_MOTOR_5;
			default: id = cmfd_pkg::ID_MOTOR_6;
		endcase
		stim_enc[s] = enc;
		send_frame(s == int'(cmfd_pkg::SLOT_BUS2_MOTOR), id, {enc, 16'($urandom), $urandom});
	endtask

	task automatic send_random();
		int          pick;
		int          s;
		int          step;
		logic [15:0] enc;
		logic [10:0] id;
		pick = $urandom_range(99);
		if (pick < 60) begin
			s    = $urandom_range(5);
			step = $urandom_range(99);
			if ($urandom_range(9) == 0) begin
				spin_up[s] = ~spin_up[s];
			end
			if (step < 70) begin
				enc = 16'($urandom_range(2500));
				enc = spin_up[s] ? stim_enc[s] + enc : stim_enc[s] - enc;
				enc = enc & 16'h1FFF;
			end else if (step < 85) begin
				enc = 16'($urandom_range(16'hFFFF));
			end else begin
				enc = $urandom_range(1) ? 16'(HALF_TURN) : 16'(HALF_TURN + 1);
				enc = $urandom_range(1) ? stim_enc[s] + enc : stim_enc[s] - enc;
			end
			send_motor(s, enc);
		end else if (pick < 75) begin
			id = $urandom_range(1) ? cmfd_pkg::ID_GIMBAL_SW : cmfd_pkg::ID_GIMBAL;
			send_frame(1'b1, id, {$urandom, $urandom});
		end else if (pick < 88) begin
			send_frame(1'($urandom), 11'($urandom), {$urandom, $urandom});
		end else begin
			case ($urandom_range(7))
				0: id = 11'h200;
				1: id = 11'h206;
				2: id = 11'h208;
				3: id = 11'h401;
				4: id = 11'h601;
				5: id = cmfd_pkg::ID_GIMBAL;
				6: id = cmfd_pkg::ID_MOTOR_5;
				default: id = cmfd_pkg::ID_MOTOR_1;
			endcase
			// drop onto the bus that ignores the identifier where one does
			send_frame((id == cmfd_pkg::ID_MOTOR_5 || id == cmfd_pkg::ID_GIMBAL) ? 1'b0 : 1'b1,
				id, {$urandom, $urandom});
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		bus        = 1'b0;
		frame_id   = '0;
		payload    = '0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		hold_left  = 0;
		sb         = new();
		foreach (stim_enc[i]) begin
			stim_enc[i] = '0;
			spin_up[i]  = 1'($urandom);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(1'b0, 11'h000, 64'h0);
		send_frame(1'b1, 11'h7FF, {64{1'b1}});
		send_motor(0, 16'h0000);
		stim_enc[1] = 16'hFFFF;
		send_frame(1'b0, cmfd_pkg::ID_MOTOR_2, {64{1'b1}});
		send_motor(2, 16'h1000);
		send_motor(3, 16'h1FFF);
		send_motor(4, 16'd100);
		send_motor(5, 16'd8000);
		for (int k = 1; k <= 5; k++) begin
			send_motor(0, 16'(300 * k));
		end
		send_frame(1'b0, cmfd_pkg::ID_MOTOR_5, {$urandom, $urandom});
		send_frame(1'b1, cmfd_pkg::ID_MOTOR_1, {$urandom, $urandom});
		send_frame(1'b0, cmfd_pkg::ID_GIMBAL, {$urandom, $urandom});
		send_frame(1'b1, cmfd_pkg::ID_GIMBAL, 64'h0);
		send_frame(1'b1, cmfd_pkg::ID_GIMBAL_SW, {64{1'b1}});
		send_frame(1'b1, cmfd_pkg::ID_GIMBAL, 64'h8000_0001_7FFF_FFFF);
		send_motor(0, 16'd8000);
		send_motor(0, 16'd100);
		send_motor(0, 16'd4196);
		send_motor(0, 16'd100);
		send_motor(0, 16'd4197);
		send_motor(0, 16'd100);

		// hold the sender until the pipeline drains
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (sb.pending() != 0);

		hold_left  = 80;
		tx_idle_en = 1'b0;
		repeat (20) send_random();
		rx_idle_en = 1'b0;
		repeat (300) send_random();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (1130) send_random();
		in_valid <= 1'b0;

		do begin
			@(posedge clk);
		end while (sb.pending() != 0);
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("can_motor_feedback_decoder_core verification clean");
		end else begin
			$display("can_motor_feedback_decoder_core verification failed");
		end
		$finish;
	end

endmodule
